/* hdl/pafo_pkg.sv */
// Shared types and constants for the alpha invert / falloff pixel stream block.
// Used by pafo_front, pafo_fade and pixel_alpha_invert_falloff.
`default_nettype none

package pafo_pkg;

    localparam int PIX_W                = 16;
    localparam int REGION_W             = 18;
    localparam int CH_W                 = 5;
    localparam int CFG_IDX_W            = 2;
    localparam int DEF_MAX_REGION_BYTES = 131072;

    localparam logic [1:0] FMT_ARGB8888 = 2'd0;
    localparam logic [1:0] FMT_ARGB1555 = 2'd1;
    localparam logic [1:0] FMT_ARGB4444 = 2'd2;
    localparam logic [1:0] FMT_UNSUP    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION  = 2'd2;

    localparam logic [1:0]          RST_FORMAT  = FMT_ARGB1555;
    localparam logic [REGION_W-1:0] RST_REGION  = 18'd2;

    typedef struct packed {
        logic             last;
        logic             err;
        logic             fade_en;
        logic             sel_blue;
        logic [PIX_W-1:0] base;
    } meta_t;

endpackage

`default_nettype wire

/* hdl/pafo_front.sv */
// Entry stage: byte position counter, region checks and per-format decode.
// Depends on pafo_pkg; registers stage 1 of the pipeline.
`default_nettype none

module pafo_front
    import pafo_pkg::*;
#(
    parameter int POS_W = $clog2(DEF_MAX_REGION_BYTES + 2)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             fire,
    input  wire logic [PIX_W-1:0] pixel,
    input  wire logic [1:0]       fmt,
    input  wire logic             falloff,
    input  wire logic [POS_W-1:0] len,
    output meta_t                 meta_q,
    output logic [CH_W-1:0]       c_q,
    output logic [CH_W-1:0]       g_q,
    output logic [POS_W-1:0]      pos_q
);

    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic [POS_W:0]   pos_ext, len_ext, pos_p1, pos_p2;
    logic             in_region, head_in;
    logic [CH_W-1:0]  r, g, b;
    logic             alpha;
    meta_t            meta_next;
    meta_t            meta_reg;
    logic [CH_W-1:0]  c_reg, g_reg;
    logic [POS_W-1:0] pos_reg;

    assign pos_ext   = {1'b0, byte_position_reg};
    assign len_ext   = {1'b0, len};
    assign pos_p1    = pos_ext + (POS_W+1)'(1);
    assign pos_p2    = pos_ext + (POS_W+1)'(2);
    assign in_region = pos_ext < len_ext;
    assign head_in   = pos_p1 < len_ext;

    assign alpha = ~pixel[15];
    assign r     = pixel[14:10];
    assign g     = pixel[9:5];
    assign b     = pixel[4:0];

    always_comb begin
        meta_next          = '0;
        meta_next.base     = pixel;
        meta_next.err      = (fmt == FMT_UNSUP);
        meta_next.last     = in_region && (pos_p2 >= len_ext);
        meta_next.sel_blue = (r < b);
        meta_next.fade_en  = in_region && (fmt == FMT_ARGB1555) && alpha && falloff;
        if (in_region) begin
            case (fmt)
                FMT_ARGB8888: begin
                    if (byte_position_reg[1:0] == 2'd2 && head_in) begin
                        meta_next.base = pixel ^ 16'hff00;
                    end
                end
                FMT_ARGB4444: begin
                    if (head_in) begin
                        meta_next.base = pixel ^ 16'hf000;
                    end
                end
                FMT_ARGB1555: begin
                    meta_next.base = alpha ? {1'b1, pixel[14:0]} : '0;
                end
                default: begin
                    meta_next.base = pixel;
                end
            endcase
        end
    end

    always_comb begin
        byte_position_next = byte_position_reg;
        if (fire && in_region) begin
            byte_position_next = pos_p2[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= '0;
        end else begin
            byte_position_reg <= byte_position_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_reg <= meta_next;
            c_reg    <= meta_next.sel_blue ? b : r;
            g_reg    <= g;
            pos_reg  <= byte_position_reg;
        end
    end

    assign meta_q = meta_reg;
    assign c_q    = c_reg;
    assign g_q    = g_reg;
    assign pos_q  = pos_reg;

endmodule

`default_nettype wire

/* hdl/pafo_fade.sv */
// One falloff lane: c * pos, then floor(c * pos / (4 * len)) one bit per stage, subtracted from c.
// Depends on pafo_pkg; four register stages, result valid with stage 5.
`default_nettype none

module pafo_fade
    import pafo_pkg::*;
#(
    parameter int POS_W = $clog2(DEF_MAX_REGION_BYTES + 2)
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic             act,
    input  wire logic [CH_W-1:0]  c,
    input  wire logic [POS_W-1:0] pos,
    input  wire logic [POS_W-1:0] len,
    output logic [CH_W-1:0]       faded
);

    localparam int NW = POS_W + CH_W;

    logic [NW-1:0]   n_reg, rem3_reg, rem4_reg;
    logic [NW-1:0]   d16, d8, d4, rem3_next, rem4_next;
    logic [CH_W-1:0] c2_reg, c3_reg, c4_reg, c5_reg;
    logic            act2_reg, act3_reg, act4_reg, act5_reg;
    logic            q2_reg;
    logic [1:0]      q4_reg;
    logic [2:0]      q5_reg;
    logic            b3, b4, b5;

    assign d16 = NW'(len) << 4;
    assign d8  = NW'(len) << 3;
    assign d4  = NW'(len) << 2;

    assign b3        = n_reg >= d16;
    assign rem3_next = b3 ? n_reg - d16 : n_reg;
    assign b4        = rem3_reg >= d8;
    assign rem4_next = b4 ? rem3_reg - d8 : rem3_reg;
    assign b5        = rem4_reg >= d4;

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg    <= NW'(c) * NW'(pos);
            c2_reg   <= c;
            act2_reg <= act;

            rem3_reg <= rem3_next;
            q2_reg   <= b3;
            c3_reg   <= c2_reg;
            act3_reg <= act2_reg;

            rem4_reg <= rem4_next;
            q4_reg   <= {q2_reg, b4};
            c4_reg   <= c3_reg;
            act4_reg <= act3_reg;

            q5_reg   <= {q4_reg, b5};
            c5_reg   <= c4_reg;
            act5_reg <= act4_reg;
        end
    end

    assign faded = c5_reg - CH_W'(q5_reg);

    // quotient of c*pos/(4*len) with pos < len can never exceed c/4
    assert property (@(posedge aclk) act5_reg |-> ({q5_reg, 2'b00} <= c5_reg))
        else $error("falloff quotient exceeds channel/4");

endmodule

`default_nettype wire

/* hdl/pixel_alpha_invert_falloff.sv */
// Top level: config registers, input skid, 5-stage pipeline and output register.
// Depends on pafo_pkg, pafo_front and pafo_fade.
//
//  channel   dir   handshake             payload
//  s_        in    s_tvalid/s_tready     s_tdata = pixel_in
//  m_        out   m_tvalid/m_tready     m_tdata = pixel_out, m_tlast, m_tuser
//  cfg_      in    cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One halfword per cycle sustained while m_tready does not stall; an accepted halfword
// passes decode, multiply, three quotient-bit stages and the output register to m_tvalid.
// aresetn clears the byte position, valid bits and falloff; format resets to ARGB1555, region to 2.
// A stall on m_tready freezes the whole pipeline; a one-entry skid on the
// input keeps s_tready a register output. cfg_ready is always high.
`default_nettype none

module pixel_alpha_invert_falloff
    import pafo_pkg::*;
#(
    parameter int MAX_REGION_BYTES = DEF_MAX_REGION_BYTES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [PIX_W-1:0]     s_tdata,    // [15:0] pixel_in
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [PIX_W-1:0]          m_tdata,    // [15:0] pixel_out
    output logic                      m_tlast,
    output logic [0:0]                m_tuser,    // [0] format_error
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REGION_W-1:0]  cfg_data
);

    localparam int POS_W = $clog2(MAX_REGION_BYTES + 2);

    logic [1:0]          fmt_reg;
    logic                falloff_reg;
    logic [REGION_W-1:0] region_reg;
    logic [31:0]         region_ext;
    logic [POS_W-1:0]    len;

    logic                skid_valid_reg, skid_valid_next;
    logic [PIX_W-1:0]    skid_data_reg;
    logic                in_valid, fire, pipe_en;
    logic [PIX_W-1:0]    in_data;

    logic [5:1]          valid_reg;
    meta_t               meta1;
    meta_t               meta_reg [2:5];
    logic [CH_W-1:0]     c1, g1, c_faded, g_faded;
    logic [POS_W-1:0]    pos1;
    logic [PIX_W-1:0]    pix5;

    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_data_reg;
    logic                out_last_reg, out_err_reg;

    // config
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg     <= RST_FORMAT;
            falloff_reg <= 1'b0;
            region_reg  <= RST_REGION;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FORMAT:  fmt_reg     <= cfg_data[1:0];
                CFG_FALLOFF: falloff_reg <= cfg_data[0];
                CFG_REGION:  region_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign region_ext = 32'(region_reg);
    assign len = (region_ext > 32'(MAX_REGION_BYTES)) ? POS_W'(MAX_REGION_BYTES)
                                                      : POS_W'(region_ext);

    // input skid and pipeline advance
    assign pipe_en  = !out_valid_reg || m_tready;
    assign s_tready = !skid_valid_reg;
    assign in_valid = skid_valid_reg || s_tvalid;
    assign in_data  = skid_valid_reg ? skid_data_reg : s_tdata;
    assign fire     = pipe_en && in_valid;

    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (pipe_en) begin
            skid_valid_next = 1'b0;
        end else if (s_tvalid && s_tready) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!pipe_en && s_tvalid && s_tready) begin
            skid_data_reg <= s_tdata;
        end
    end

    pafo_front #(
        .POS_W (POS_W)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .fire    (fire),
        .pixel   (in_data),
        .fmt     (fmt_reg),
        .falloff (falloff_reg),
        .len     (len),
        .meta_q  (meta1),
        .c_q     (c1),
        .g_q     (g1),
        .pos_q   (pos1)
    );

    pafo_fade #(
        .POS_W (POS_W)
    ) u_fade_c (
        .aclk  (aclk),
        .en    (pipe_en),
        .act   (valid_reg[1] && meta1.fade_en),
        .c     (c1),
        .pos   (pos1),
        .len   (len),
        .faded (c_faded)
    );

    pafo_fade #(
        .POS_W (POS_W)
    ) u_fade_g (
        .aclk  (aclk),
        .en    (pipe_en),
        .act   (valid_reg[1] && meta1.fade_en),
        .c     (g1),
        .pos   (pos1),
        .len   (len),
        .faded (g_faded)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[4:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            meta_reg[2] <= meta1;
            meta_reg[3] <= meta_reg[2];
            meta_reg[4] <= meta_reg[3];
            meta_reg[5] <= meta_reg[4];
        end
    end

    always_comb begin
        pix5 = meta_reg[5].base;
        if (meta_reg[5].fade_en) begin
            pix5[9:5] = g_faded;
            if (meta_reg[5].sel_blue) begin
                pix5[4:0] = c_faded;
            end else begin
                pix5[14:10] = c_faded;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= valid_reg[5];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_data_reg <= pix5;
            out_last_reg <= meta_reg[5].last;
            out_err_reg  <= meta_reg[5].err;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_err_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> $past(!pipe_en))
        else $error("skid holds data while pipeline advanced");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(out_valid_reg) |-> $past(m_tready))
        else $error("result dropped without transaction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (!pipe_en && valid_reg[5]) |=> valid_reg[5])
        else $error("stage 5 item lost during stall");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for pixel_alpha_invert_falloff: directed rows, random region
// phases, odd region lengths; random idling on both stream channels; predictor-checked.
// Depends on pafo_pkg and the RTL of pixel_alpha_invert_falloff.
`timescale 1ns / 1ps

module testbench;
    import pafo_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             err;
    } halfword_result_t;

    typedef enum bit {ROW_PIXEL, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [REGION_W-1:0]   value;
        logic [PIX_W-1:0]      pixel;
        bit                    typed;
        halfword_result_t      want;
    } directed_row_t;

    localparam halfword_result_t NONE = '{16'h0000, 1'b0, 1'b0};

    localparam directed_row_t DIRECTED_ROWS [25] = '{
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'h0000, 1'b1, '{16'h8000, 1'b1, 1'b0}},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_REGION,   18'd0,       16'h0000, 1'b0, NONE},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'h1234, 1'b1, '{16'h1234, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_UNMAPPED, 18'h3FFFF,   16'h0000, 1'b0, NONE},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'h5A5A, 1'b1, '{16'h5A5A, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_REGION,   18'h3FFFF,   16'h0000, 1'b0, NONE},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'h7FFF, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_FALLOFF,  18'd1,       16'h0000, 1'b0, NONE},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'h7FFF, 1'b0, NONE},
        '{ROW_WRITE, CFG_FORMAT,   18'd0,       16'h0000, 1'b0, NONE},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'hFFFF, 1'b1, '{16'h00FF, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_FORMAT,   18'd2,       16'h0000, 1'b0, NONE},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'h0000, 1'b1, '{16'hF000, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'hFFFF, 1'b1, '{16'h0FFF, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_FORMAT,   18'd3,       16'h0000, 1'b0, NONE},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'hA5A5, 1'b1, '{16'hA5A5, 1'b0, 1'b1}},
        '{ROW_WRITE, CFG_REGION,   18'd22,      16'h0000, 1'b0, NONE},
        '{ROW_WRITE, CFG_FORMAT,   18'd1,       16'h0000, 1'b0, NONE},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'h7C1F, 1'b0, NONE},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'h03FF, 1'b0, NONE},
        '{ROW_PIXEL, CFG_FORMAT,   18'd0,       16'h8000, 1'b1, '{16'h8000, 1'b0, 1'b0}},
        '{ROW_WRITE, CFG_REGION,   18'h20000,   16'h0000, 1'b0, NONE}
    };

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [PIX_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REGION_W-1:0]  cfg_data  = '0;

    // predictor state
    logic [1:0]          fmt_reg     = RST_FORMAT;
    logic                falloff_reg = 1'b0;
    logic [REGION_W-1:0] region_reg  = RST_REGION;
    int unsigned         region_pos  = 0;

    halfword_result_t pending_pixels [$];
    int  items_sent = 0;
    int  mismatches = 0;
    bit  tx_quiet   = 1'b0;
    bit  rx_quiet   = 1'b0;
    bit  hold_req   = 1'b0;

    pixel_alpha_invert_falloff dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CH_W-1:0] dim_channel(int unsigned c, int unsigned pos,
                                                    int unsigned len);
        int unsigned v;
        v = c - (c * pos / len) / 4;
        return (v >= 32) ? 5'd31 : CH_W'(v);
    endfunction

    // Expected result for one halfword; advances the byte position while inside the region.
    function automatic halfword_result_t invert_alpha(logic [PIX_W-1:0] px);
        halfword_result_t r;
        int unsigned      len;
        logic             alpha;
        logic [CH_W-1:0]  red, grn, blu;
        len     = (region_reg > DEF_MAX_REGION_BYTES) ? DEF_MAX_REGION_BYTES : region_reg;
        r.pixel = px;
        r.last  = 1'b0;
        r.err   = (fmt_reg == FMT_UNSUP);
        if (region_pos < len) begin
            r.last = (region_pos + 2 >= len);
            case (fmt_reg)
                FMT_ARGB8888: begin
                    if (region_pos % 4 == 2 && region_pos + 1 < len) r.pixel = px ^ 16'hFF00;
                end
                FMT_ARGB4444: begin
                    if (region_pos + 1 < len) r.pixel = px ^ 16'hF000;
                end
                FMT_ARGB1555: begin
                    alpha = ~px[15];
                    red   = px[14:10];
                    grn   = px[9:5];
                    blu   = px[4:0];
                    if (!alpha) begin
                        red = '0;
                        grn = '0;
                        blu = '0;
                    end else if (falloff_reg) begin
                        if (red < blu) blu = dim_channel(blu, region_pos, len);
                        else red = dim_channel(red, region_pos, len);
                        grn = dim_channel(grn, region_pos, len);
                    end
                    r.pixel = {alpha, red, grn, blu};
                end
                default: ;
            endcase
            region_pos = region_pos + 2;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input halfword_result_t want);
        halfword_result_t predicted;
        int               gap;
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = invert_alpha(px);
        pending_pixels.push_back(typed ? want : predicted);
        items_sent++;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REGION_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_FORMAT:  fmt_reg     = data[1:0];
            CFG_FALLOFF: falloff_reg = data[0];
            CFG_REGION:  region_reg  = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin : check_results
        halfword_result_t want;
        halfword_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tlast, m_tuser[0]};
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction pixel %h last %b err %b",
                                          got.pixel, got.last, got.err));
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "pixel %h last %b err %b, expected pixel %h last %b err %b",
                        got.pixel, got.last, got.err, want.pixel, want.last, want.err));
            end
        end
    end

    initial begin : result_sink
        int stall;
        stall = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                // long back-pressure: the input side must fill up and stall
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
                hold_req = 1'b0;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    initial begin : stimulus
        int                  phase;
        int                  span;
        int                  count;
        int                  pick;
        logic [1:0]          fmt;
        logic [REGION_W-1:0] region;
        logic [REGION_W-1:0] word;
        logic [1:0]          odd_fmts [3];

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].value);
            end else begin
                send_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].typed,
                           DIRECTED_ROWS[i].want);
            end
        end

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            wait_idle();
            pick = $urandom_range(0, 9);
            if (pick < 4)       fmt = FMT_ARGB1555;
            else if (pick < 6)  fmt = FMT_ARGB8888;
            else if (pick < 8)  fmt = FMT_ARGB4444;
            else if (pick == 8) fmt = FMT_UNSUP;
            else                fmt = 2'($urandom);
            word = REGION_W'($urandom);
            word[1:0] = fmt;
            write_reg(CFG_FORMAT, word);
            write_reg(CFG_FALLOFF, REGION_W'($urandom));
            if ($urandom_range(0, 7) == 0) write_reg(CFG_UNMAPPED, REGION_W'($urandom));

            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 19);
            span = 2 * $urandom_range(4, 60);
            if (phase == 4 || phase == 15) begin
                span     = 120;
                region   = REGION_W'(region_pos + span);
                count    = span / 2 + 8;
                tx_quiet = 1'b1;
                hold_req = 1'b1;
            end else if (pick == 0) begin
                // region already behind the position: pass-through only
                region = REGION_W'($urandom_range(0, region_pos));
                count  = $urandom_range(4, 12);
            end else if (pick == 1) begin
                region = REGION_W'($urandom_range(region_pos + 2, 18'h3FFFF));
                count  = $urandom_range(10, 40);
            end else begin
                region = REGION_W'(region_pos + span);
                count  = span / 2 + $urandom_range(0, 3);
            end
            write_reg(CFG_REGION, region);
            repeat (count) send_pixel(PIX_W'($urandom), 1'b0, NONE);
            phase++;
        end

        // odd region lengths: last halfword straddles the region end
        odd_fmts = '{FMT_ARGB8888, FMT_ARGB4444, FMT_ARGB1555};
        foreach (odd_fmts[i]) begin
            wait_idle();
            write_reg(CFG_FORMAT, REGION_W'(odd_fmts[i]));
            span = 2 * $urandom_range(4, 30);
            if ((region_pos + span) % 4 != 2) span += 2;
            write_reg(CFG_REGION, REGION_W'(region_pos + span + 1));
            repeat (span / 2 + 3) send_pixel(PIX_W'($urandom), 1'b0, NONE);
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
